### hdl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    // Default values of the top-level parameters.
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int MAX_CODE_LEN_DEF  = 64;

    // Fixed field widths.
    localparam int FREQ_W   = 24;
    localparam int CODE_W   = 64;
    localparam int LEN_W    = 7;
    localparam int NODE_W   = 9;
    localparam int WEIGHT_W = 32;

    // Store geometry.
    localparam int SYM_DEPTH  = 256;
    localparam int LIST_DEPTH = 512;
    localparam int LIST_W     = WEIGHT_W + NODE_W;
    localparam int CHILD_W    = 2 * NODE_W;
    localparam int STACK_W    = CODE_W + 2 * NODE_W;
    localparam int CODE_MEM_W = LEN_W + CODE_W;

    // Operation codes.
    localparam logic [2:0] FN_COUNT  = 3'd0;
    localparam logic [2:0] FN_BUILD  = 3'd1;
    localparam logic [2:0] FN_ENCODE = 3'd2;
    localparam logic [2:0] FN_RANK   = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    // Status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NONE    = 2'd1;
    localparam logic [1:0] STAT_LONG    = 2'd2;
    localparam logic [1:0] STAT_UNBUILT = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CNT,
        S_RANK,
        S_REP,
        S_EMIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_INS,
        S_INS_CMP,
        S_ONE,
        S_MERGE,
        S_M_RD1,
        S_M_SUM,
        S_ROOT,
        S_NODE,
        S_CHILD,
        S_POP
    } state_t;

    // One result word, status in the lowest bits.
    typedef struct packed {
        logic [8:0]        distinct;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_bits;
        logic [FREQ_W-1:0] frequency;
        logic [7:0]        symbol;
        logic [1:0]        status;
    } result_t;

endpackage

### hdl/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module hcb_ram
    import hcb_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// Counts byte frequencies, builds Huffman codes and answers encode and
// leaf-rank queries.
// ----------------------------------------------------------------------------
// Channel  Dir  Width  Contents
// s_axis   in   24     func, byte_value, leaf_rank
// m_axis   out  120    status, symbol, frequency, code_bits, code_length,
//                      distinct_symbols
//
// A leaf-rank read makes two dependent RAM reads: the leaf symbol, then its
// count and code. Build scans every alphabet entry, compares list entries
// during each sorted insertion, merges the two front nodes and inserts the
// new one, and then walks the tree depth-first.
// Reset clears counts through per-entry valid flops; no clearing pass.
// A finished word waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // func[2:0], byte_value[10:3], leaf_rank[18:11]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // status[1:0], symbol[9:2], frequency[33:10],
                                    // code_bits[97:34], code_length[104:98],
                                    // distinct_symbols[113:105]
);

    // Input fields.
    logic [2:0] in_func;
    logic [7:0] in_byte;
    logic [7:0] in_rank;
    logic       accept;

    assign in_func = s_tdata[2:0];
    assign in_byte = s_tdata[10:3];
    assign in_rank = s_tdata[18:11];

    // Control and datapath registers.
    state_t                state_reg, state_next;
    logic [SYM_DEPTH-1:0]  cnt_vld_reg, cnt_vld_next;
    logic                  cnt_vq_reg, cnt_vq_next;
    logic [7:0]            sym_reg, sym_next;
    logic [8:0]            s_reg, s_next;
    logic [8:0]            head_reg, head_next;
    logic [8:0]            tail_reg, tail_next;
    logic [8:0]            k_reg, k_next;
    logic [LIST_W-1:0]     new_reg, new_next;
    logic [LIST_W-1:0]     a_reg, a_next;
    logic                  after_reg, after_next;
    logic                  phase_reg, phase_next;
    logic [7:0]            nxt_reg, nxt_next;
    logic [NODE_W-1:0]     cur_reg, cur_next;
    logic [8:0]            dep_reg, dep_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [8:0]            sp_reg, sp_next;
    logic [8:0]            rank_reg, rank_next;
    logic                  long_reg, long_next;
    logic                  ready_reg, ready_next;
    logic [8:0]            total_reg, total_next;
    result_t               rs_reg, rs_next;
    result_t               out_reg, out_next;
    logic                  out_vld_reg, out_vld_next;

    // RAM ports.
    logic                  cnt_we, cnt_re;
    logic [7:0]            cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
    logic                  list_we, list_re;
    logic [8:0]            list_waddr, list_raddr;
    logic [LIST_W-1:0]     list_wdata, list_rd;
    logic                  child_we, child_re;
    logic [7:0]            child_waddr, child_raddr;
    logic [CHILD_W-1:0]    child_wdata, child_rd;
    logic                  stack_we, stack_re;
    logic [7:0]            stack_waddr, stack_raddr;
    logic [STACK_W-1:0]    stack_wdata, stack_rd;
    logic                  code_we, code_re;
    logic [7:0]            code_waddr, code_raddr;
    logic [CODE_MEM_W-1:0] code_wdata, code_rd;
    logic                  leaf_we, leaf_re;
    logic [7:0]            leaf_waddr, leaf_raddr;
    logic [7:0]            leaf_wdata, leaf_rd;

    // Derived values.
    logic [COUNT_BITS-1:0] cnt_val, cnt_inc;
    logic [31:0]           cnt_wide, inc_wide;
    logic                  out_free;
    logic                  in_range;
    logic [WEIGHT_W:0]     wsum;
    logic [WEIGHT_W-1:0]   wsat;
    logic [WEIGHT_W-1:0]   list_w, new_w;
    logic                  shift_up;
    logic                  too_deep;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !out_vld_reg || m_tready;
    assign in_range  = ({1'b0, in_byte} < 9'(ALPHABET_SIZE));
    assign cnt_val   = cnt_vq_reg ? cnt_rd : '0;
    assign cnt_inc   = (cnt_val == {COUNT_BITS{1'b1}}) ? cnt_val : cnt_val + COUNT_BITS'(1);
    assign cnt_wide  = 32'(cnt_val);
    assign inc_wide  = 32'(cnt_inc);
    assign wsum      = {1'b0, a_reg[LIST_W-1:NODE_W]} + {1'b0, list_rd[LIST_W-1:NODE_W]};
    assign wsat      = wsum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : wsum[WEIGHT_W-1:0];
    assign list_w    = list_rd[LIST_W-1:NODE_W];
    assign new_w     = new_reg[LIST_W-1:NODE_W];
    assign shift_up  = after_reg ? (list_w > new_w) : (list_w >= new_w);
    assign too_deep  = (dep_reg > 9'(MAX_CODE_LEN));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        FN_COUNT:  state_next = in_range ? S_CNT : S_EMIT;
                        FN_BUILD:  state_next = S_SCAN_RD;
                        FN_ENCODE: state_next = (ready_reg && in_range) ? S_REP : S_EMIT;
                        FN_RANK:   state_next = (ready_reg && ({1'b0, in_rank} < total_reg))
                                                ? S_RANK : S_EMIT;
                        default:   state_next = S_EMIT;
                    endcase
                end
            end
            S_CNT:      state_next = out_free ? S_IDLE : S_CNT;
            S_RANK:     state_next = S_REP;
            S_REP:      state_next = S_EMIT;
            S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
            S_SCAN_RD:
            begin
                if (s_reg != 9'(ALPHABET_SIZE))
                    state_next = S_SCAN_CHK;
                else if (tail_reg == 9'd0)
                    state_next = S_EMIT;
                else if (tail_reg == 9'd1)
                    state_next = S_ONE;
                else
                    state_next = S_MERGE;
            end
            S_SCAN_CHK: state_next = (cnt_val != '0) ? S_INS : S_SCAN_RD;
            S_INS:
            begin
                if (k_reg != head_reg)
                    state_next = S_INS_CMP;
                else
                    state_next = phase_reg ? S_MERGE : S_SCAN_RD;
            end
            S_INS_CMP:
            begin
                if (shift_up)
                    state_next = S_INS;
                else
                    state_next = phase_reg ? S_MERGE : S_SCAN_RD;
            end
            S_ONE:      state_next = S_EMIT;
            S_MERGE:    state_next = ((tail_reg - head_reg) > 9'd1) ? S_M_RD1 : S_ROOT;
            S_M_RD1:    state_next = S_M_SUM;
            S_M_SUM:    state_next = S_INS;
            S_ROOT:     state_next = S_NODE;
            S_NODE:
            begin
                if (cur_reg[NODE_W-1])
                    state_next = S_CHILD;
                else if (sp_reg == 9'd0)
                    state_next = S_EMIT;
                else
                    state_next = S_POP;
            end
            S_CHILD:    state_next = S_NODE;
            S_POP:      state_next = S_NODE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM controls and result assembly.
    always_comb
    begin
        cnt_vld_next = cnt_vld_reg;
        cnt_vq_next  = cnt_vq_reg;
        sym_next     = sym_reg;
        s_next       = s_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        k_next       = k_reg;
        new_next     = new_reg;
        a_next       = a_reg;
        after_next   = after_reg;
        phase_next   = phase_reg;
        nxt_next     = nxt_reg;
        cur_next     = cur_reg;
        dep_next     = dep_reg;
        code_next    = code_reg;
        sp_next      = sp_reg;
        rank_next    = rank_reg;
        long_next    = long_reg;
        ready_next   = ready_reg;
        total_next   = total_reg;
        rs_next      = rs_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;

        cnt_we = 1'b0;  cnt_waddr = sym_reg;  cnt_wdata = cnt_inc;
        cnt_re = 1'b0;  cnt_raddr = in_byte;
        list_we = 1'b0; list_waddr = k_reg;   list_wdata = new_reg;
        list_re = 1'b0; list_raddr = head_reg;
        child_we = 1'b0; child_waddr = nxt_reg;
        child_wdata = {a_reg[NODE_W-1:0], list_rd[NODE_W-1:0]};
        child_re = 1'b0; child_raddr = cur_reg[7:0];
        stack_we = 1'b0; stack_waddr = sp_reg[7:0];
        stack_wdata = {code_reg[CODE_W-2:0], 1'b1, dep_reg + 9'd1, child_rd[NODE_W-1:0]};
        stack_re = 1'b0; stack_raddr = 8'(sp_reg - 9'd1);
        code_we = 1'b0; code_waddr = cur_reg[7:0];
        code_wdata = too_deep ? '0 : {LEN_W'(dep_reg), code_reg};
        code_re = 1'b0; code_raddr = in_byte;
        leaf_we = 1'b0; leaf_waddr = rank_reg[7:0]; leaf_wdata = cur_reg[7:0];
        leaf_re = 1'b0; leaf_raddr = in_rank;

        // The output register empties when its word is taken.
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rs_next          = '0;
                    rs_next.distinct = total_reg;
                    unique case (in_func)
                        FN_COUNT:
                        begin
                            if (in_range)
                            begin
                                cnt_re      = 1'b1;
                                cnt_vq_next = cnt_vld_reg[in_byte];
                                sym_next    = in_byte;
                            end
                            else
                            begin
                                rs_next.status = STAT_NONE;
                            end
                        end
                        FN_BUILD:
                        begin
                            s_next     = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            nxt_next   = '0;
                            long_next  = 1'b0;
                            phase_next = 1'b0;
                        end
                        FN_ENCODE:
                        begin
                            if (!ready_reg)
                            begin
                                rs_next.status = STAT_UNBUILT;
                            end
                            else if (!in_range)
                            begin
                                rs_next.status = STAT_NONE;
                                rs_next.symbol = in_byte;
                            end
                            else
                            begin
                                cnt_re      = 1'b1;
                                code_re     = 1'b1;
                                cnt_vq_next = cnt_vld_reg[in_byte];
                                sym_next    = in_byte;
                            end
                        end
                        FN_RANK:
                        begin
                            if (!ready_reg)
                                rs_next.status = STAT_UNBUILT;
                            else if ({1'b0, in_rank} >= total_reg)
                                rs_next.status = STAT_NONE;
                            else
                                leaf_re = 1'b1;
                        end
                        FN_CLEAR:
                        begin
                            cnt_vld_next     = '0;
                            ready_next       = 1'b0;
                            total_next       = '0;
                            rs_next.distinct = '0;
                        end
                        default:
                        begin
                            rs_next.status = STAT_NONE;
                        end
                    endcase
                end
            end

            // Count write-back and result load happen together once the output register is free.
            S_CNT:
            begin
                if (out_free)
                begin
                    cnt_we                = 1'b1;
                    cnt_vld_next[sym_reg] = 1'b1;
                    ready_next            = 1'b0;
                    total_next            = '0;
                    out_next              = '0;
                    out_next.symbol       = sym_reg;
                    out_next.frequency    = inc_wide[FREQ_W-1:0];
                    out_vld_next          = 1'b1;
                end
            end

            // Leaf symbol arrives; look up its count and code.
            S_RANK:
            begin
                sym_next    = leaf_rd;
                cnt_re      = 1'b1;
                code_re     = 1'b1;
                cnt_raddr   = leaf_rd;
                code_raddr  = leaf_rd;
                cnt_vq_next = cnt_vld_reg[leaf_rd];
            end

            S_REP:
            begin
                rs_next          = '0;
                rs_next.distinct = total_reg;
                rs_next.symbol   = sym_reg;
                if (cnt_val == '0)
                begin
                    rs_next.status = STAT_NONE;
                end
                else
                begin
                    rs_next.frequency = cnt_wide[FREQ_W-1:0];
                    if (code_rd[CODE_MEM_W-1:CODE_W] == '0)
                    begin
                        rs_next.status = STAT_LONG;
                    end
                    else
                    begin
                        rs_next.code_bits   = code_rd[CODE_W-1:0];
                        rs_next.code_length = code_rd[CODE_MEM_W-1:CODE_W];
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next     = rs_reg;
                    out_vld_next = 1'b1;
                end
            end

            // Walk the alphabet; finish the scan when every entry was seen.
            S_SCAN_RD:
            begin
                if (s_reg != 9'(ALPHABET_SIZE))
                begin
                    cnt_re      = 1'b1;
                    cnt_raddr   = s_reg[7:0];
                    cnt_vq_next = cnt_vld_reg[s_reg[7:0]];
                end
                else
                begin
                    ready_next       = 1'b1;
                    total_next       = tail_reg;
                    rs_next          = '0;
                    rs_next.distinct = tail_reg;
                    if (tail_reg == 9'd0)
                    begin
                        rs_next.status = STAT_NONE;
                    end
                    else if (tail_reg == 9'd1)
                    begin
                        list_re    = 1'b1;
                        list_raddr = '0;
                    end
                end
            end

            S_SCAN_CHK:
            begin
                s_next = s_reg + 9'd1;
                if (cnt_val != '0)
                begin
                    new_next   = {cnt_wide, s_reg};
                    k_next     = tail_reg;
                    after_next = 1'b1;
                end
            end

            // Sorted insertion: move larger entries, and for merged nodes equal ones too, up one place from the tail.
            S_INS:
            begin
                if (k_reg != head_reg)
                begin
                    list_re    = 1'b1;
                    list_raddr = k_reg - 9'd1;
                end
                else
                begin
                    list_we   = 1'b1;
                    tail_next = tail_reg + 9'd1;
                end
            end

            S_INS_CMP:
            begin
                list_we = 1'b1;
                if (shift_up)
                begin
                    list_wdata = list_rd;
                    k_next     = k_reg - 9'd1;
                end
                else
                begin
                    tail_next = tail_reg + 9'd1;
                end
            end

            // A lone symbol gets the one-bit code zero.
            S_ONE:
            begin
                code_we    = 1'b1;
                code_waddr = list_rd[7:0];
                code_wdata = {LEN_W'(1), {CODE_W{1'b0}}};
                leaf_we    = 1'b1;
                leaf_waddr = '0;
                leaf_wdata = list_rd[7:0];
            end

            S_MERGE:
            begin
                list_re    = 1'b1;
                list_raddr = head_reg;
            end

            S_M_RD1:
            begin
                a_next     = list_rd;
                list_re    = 1'b1;
                list_raddr = head_reg + 9'd1;
            end

            // Merge the two front nodes and insert the new one.
            S_M_SUM:
            begin
                child_we   = 1'b1;
                new_next   = {wsat, 1'b1, nxt_reg};
                nxt_next   = nxt_reg + 8'd1;
                head_next  = head_reg + 9'd2;
                k_next     = tail_reg;
                after_next = 1'b0;
                phase_next = 1'b1;
            end

            S_ROOT:
            begin
                cur_next  = list_rd[NODE_W-1:0];
                dep_next  = '0;
                code_next = '0;
                sp_next   = '0;
                rank_next = '0;
            end

            // Depth-first walk, zero branch first; one branches wait on the stack.
            S_NODE:
            begin
                if (cur_reg[NODE_W-1])
                begin
                    child_re = 1'b1;
                end
                else
                begin
                    code_we   = 1'b1;
                    leaf_we   = 1'b1;
                    rank_next = rank_reg + 9'd1;
                    if (too_deep)
                    begin
                        long_next = 1'b1;
                    end
                    if (sp_reg == 9'd0)
                    begin
                        rs_next          = '0;
                        rs_next.distinct = total_reg;
                        rs_next.status   = (long_reg || too_deep) ? STAT_LONG : STAT_OK;
                    end
                    else
                    begin
                        stack_re = 1'b1;
                        sp_next  = sp_reg - 9'd1;
                    end
                end
            end

            S_CHILD:
            begin
                stack_we  = 1'b1;
                sp_next   = sp_reg + 9'd1;
                cur_next  = child_rd[CHILD_W-1:NODE_W];
                dep_next  = dep_reg + 9'd1;
                code_next = {code_reg[CODE_W-2:0], 1'b0};
            end

            S_POP:
            begin
                cur_next  = stack_rd[NODE_W-1:0];
                dep_next  = stack_rd[2*NODE_W-1:NODE_W];
                code_next = stack_rd[STACK_W-1:2*NODE_W];
            end

            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_vld_reg <= '0;
            ready_reg   <= 1'b0;
            total_reg   <= '0;
            out_vld_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            sp_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_vld_reg <= cnt_vld_next;
            ready_reg   <= ready_next;
            total_reg   <= total_next;
            out_vld_reg <= out_vld_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            sp_reg      <= sp_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cnt_vq_reg <= cnt_vq_next;
        sym_reg    <= sym_next;
        s_reg      <= s_next;
        k_reg      <= k_next;
        new_reg    <= new_next;
        a_reg      <= a_next;
        after_reg  <= after_next;
        phase_reg  <= phase_next;
        nxt_reg    <= nxt_next;
        cur_reg    <= cur_next;
        dep_reg    <= dep_next;
        code_reg   <= code_next;
        rank_reg   <= rank_next;
        long_reg   <= long_next;
        rs_reg     <= rs_next;
        out_reg    <= out_next;
    end

    // Byte counts.
    hcb_ram #(.DEPTH(SYM_DEPTH), .WIDTH(COUNT_BITS)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rd)
    );

    // Sorted node list, weight above node id.
    hcb_ram #(.DEPTH(LIST_DEPTH), .WIDTH(LIST_W)) u_list_ram (
        .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
        .re(list_re), .raddr(list_raddr), .rdata(list_rd)
    );

    // Children of merged nodes, zero branch above one branch.
    hcb_ram #(.DEPTH(SYM_DEPTH), .WIDTH(CHILD_W)) u_child_ram (
        .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
        .re(child_re), .raddr(child_raddr), .rdata(child_rd)
    );

    // Pending one branches of the walk.
    hcb_ram #(.DEPTH(SYM_DEPTH), .WIDTH(STACK_W)) u_stack_ram (
        .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .re(stack_re), .raddr(stack_raddr), .rdata(stack_rd)
    );

    // Code length above code bits, per symbol.
    hcb_ram #(.DEPTH(SYM_DEPTH), .WIDTH(CODE_MEM_W)) u_code_ram (
        .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
        .re(code_re), .raddr(code_raddr), .rdata(code_rd)
    );

    // Symbols in walk order.
    hcb_ram #(.DEPTH(SYM_DEPTH), .WIDTH(8)) u_leaf_ram (
        .clk(clk), .we(leaf_we), .waddr(leaf_waddr), .wdata(leaf_wdata),
        .re(leaf_re), .raddr(leaf_raddr), .rdata(leaf_rd)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg};

    // Every accepted word moves the sequencer out of idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after taking a word");

    // A result leaving the emit state lands in the output register.
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> m_tvalid)
        else $error("emitted result not presented");

    // The list never has its head past its tail.
    a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg >= head_reg)
        else $error("node list head passed tail");

    // The walk stack stays within its RAM.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !sp_reg[8])
        else $error("walk stack overflow");

endmodule

### test/huffman_code_builder_tb.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_tb
// Self-checking bench for the Huffman code builder. A directed table covers
// the empty, lone-symbol, unbuilt and out-of-range cases. It is followed by
// random phases of the form clear (in most phases), count, build and query.
// Each result word is checked against its typed table value or a behavioral copy.
// ----------------------------------------------------------------------------
module huffman_code_builder_tb;
    import hcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL   = 750;
    localparam int STALL_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;   // func[2:0], byte_value[10:3], leaf_rank[18:11]
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;   // status, symbol, frequency, code_bits, code_length, distinct

    huffman_code_builder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the builder state.
    logic [23:0] sh_count [256];
    logic [31:0] sh_weight [511];
    int          sh_zero [511];
    int          sh_one [511];
    int          sh_list [256];
    logic [63:0] sh_code [256];
    int          sh_len [256];
    int          sh_leaf [256];
    int          sh_leaves;
    bit          sh_ready;

    result_t pending_words [$];
    int      error_count;
    int      items_sent;
    int      words_checked;
    int      builds_sent;
    bit      hold_req;
    bit      quiet;

    // Sorted insertion into the working list.
    function automatic void list_put(inout int n, input int node, input bit after_eq);
        int pos;
        pos = 0;
        while (pos < n)
        begin
            if (after_eq ? (sh_weight[sh_list[pos]] > sh_weight[node])
                         : (sh_weight[sh_list[pos]] >= sh_weight[node]))
                break;
            pos++;
        end
        for (int k = n; k > pos; k--)
            sh_list[k] = sh_list[k-1];
        sh_list[pos] = node;
        n++;
    endfunction

    // Builds the tree and the code table; returns the build status.
    function automatic logic [1:0] build_tree();
        int          n;
        int          nxt;
        int          sp;
        int          rank;
        int          a;
        int          b;
        int          nd;
        int          d;
        logic [32:0] sum;
        logic [63:0] c;
        bit          too_long;
        int          st_node [512];
        int          st_depth [512];
        logic [63:0] st_code [512];
        n = 0;
        nxt = 256;
        rank = 0;
        too_long = 1'b0;
        for (int s = 0; s < 256; s++)
            sh_len[s] = 0;
        for (int s = 0; s < 256; s++)
        begin
            if (sh_count[s] != 0)
            begin
                sh_weight[s] = 32'(sh_count[s]);
                list_put(n, s, 1'b1);
            end
        end
        sh_ready = 1'b1;
        sh_leaves = n;
        if (n == 0)
            return STAT_NONE;
        if (n == 1)
        begin
            sh_code[sh_list[0]] = '0;
            sh_len[sh_list[0]] = 1;
            sh_leaf[0] = sh_list[0];
            return STAT_OK;
        end
        while (n > 1)
        begin
            a = sh_list[0];
            b = sh_list[1];
            sum = {1'b0, sh_weight[a]} + {1'b0, sh_weight[b]};
            sh_weight[nxt] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            sh_zero[nxt] = a;
            sh_one[nxt] = b;
            for (int k = 2; k < n; k++)
                sh_list[k-2] = sh_list[k];
            n -= 2;
            list_put(n, nxt, 1'b0);
            nxt++;
        end
        // Depth-first walk, zero branch first.
        st_node[0] = sh_list[0];
        st_depth[0] = 0;
        st_code[0] = '0;
        sp = 1;
        while (sp > 0)
        begin
            sp--;
            nd = st_node[sp];
            d = st_depth[sp];
            c = st_code[sp];
            if (nd < 256)
            begin
                if (rank < 256)
                    sh_leaf[rank] = nd;
                rank++;
                if (d <= MAX_CODE_LEN_DEF)
                begin
                    sh_code[nd] = (d >= 64) ? c : (c & ((64'd1 << d) - 64'd1));
                    sh_len[nd] = d;
                end
                else
                begin
                    sh_code[nd] = '0;
                    sh_len[nd] = 0;
                    too_long = 1'b1;
                end
            end
            else
            begin
                st_node[sp] = sh_one[nd];
                st_depth[sp] = d + 1;
                st_code[sp] = {c[62:0], 1'b1};
                sp++;
                st_node[sp] = sh_zero[nd];
                st_depth[sp] = d + 1;
                st_code[sp] = {c[62:0], 1'b0};
                sp++;
            end
        end
        return too_long ? STAT_LONG : STAT_OK;
    endfunction

    // Fills in the code fields for one built symbol.
    function automatic result_t symbol_word(int s);
        result_t r;
        r = '0;
        r.symbol = 8'(s);
        r.frequency = sh_count[s];
        if (sh_len[s] == 0)
            r.status = STAT_LONG;
        else
        begin
            r.code_bits = sh_code[s];
            r.code_length = LEN_W'(sh_len[s]);
        end
        return r;
    endfunction

    // Applies one word to the shadow state and returns the expected result.
    function automatic result_t next_result(logic [2:0] fn, logic [7:0] bv, logic [7:0] rk);
        result_t r;
        r = '0;
        case (fn)
            FN_COUNT:
            begin
                if (sh_count[bv] != 24'hFF_FFFF)
                    sh_count[bv]++;
                sh_ready = 1'b0;
                sh_leaves = 0;
                r.symbol = bv;
                r.frequency = sh_count[bv];
            end
            FN_BUILD:
                r.status = build_tree();
            FN_ENCODE:
            begin
                if (!sh_ready)
                    r.status = STAT_UNBUILT;
                else if (sh_count[bv] == 0)
                begin
                    r.status = STAT_NONE;
                    r.symbol = bv;
                end
                else
                    r = symbol_word(bv);
            end
            FN_RANK:
            begin
                if (!sh_ready)
                    r.status = STAT_UNBUILT;
                else if (rk >= sh_leaves)
                    r.status = STAT_NONE;
                else
                    r = symbol_word(sh_leaf[rk]);
            end
            FN_CLEAR:
            begin
                for (int s = 0; s < 256; s++)
                begin
                    sh_count[s] = '0;
                    sh_len[s] = 0;
                end
                sh_leaves = 0;
                sh_ready = 1'b0;
            end
            default:
                r.status = STAT_NONE;
        endcase
        r.distinct = 9'(sh_leaves);
        return r;
    endfunction

    // Offers one word, waits for the handshake and records the expectation.
    task automatic send_word(logic [2:0] fn, logic [7:0] bv, logic [7:0] rk,
                             bit typed, result_t typed_val);
        int      gap;
        result_t r;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, rk, bv, fn};
        do @(posedge clk); while (!s_tready);
        r = next_result(fn, bv, rk);
        pending_words.push_back(typed ? typed_val : r);
        items_sent++;
        if (fn == FN_BUILD)
            builds_sent++;
    endtask

    // Drops valid and waits until every expected word has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls per word, plus one long hold-off on request.
    initial
    begin
        bit hold_done;
        m_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            if (hold_req && !hold_done)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_t got;
            result_t want;
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (got.status != want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    error_count++;
                end
                if (got.symbol != want.symbol)
                begin
                    $display("%0t: symbol exp %0d got %0d", $time, want.symbol, got.symbol);
                    error_count++;
                end
                if (got.frequency != want.frequency)
                begin
                    $display("%0t: frequency exp %0d got %0d", $time,
                             want.frequency, got.frequency);
                    error_count++;
                end
                if (got.code_bits != want.code_bits)
                begin
                    $display("%0t: code_bits exp %h got %h", $time,
                             want.code_bits, got.code_bits);
                    error_count++;
                end
                if (got.code_length != want.code_length)
                begin
                    $display("%0t: code_length exp %0d got %0d", $time,
                             want.code_length, got.code_length);
                    error_count++;
                end
                if (got.distinct != want.distinct)
                begin
                    $display("%0t: distinct exp %0d got %0d", $time,
                             want.distinct, got.distinct);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Directed table: typed expectations only where obvious.
    typedef struct {
        logic [2:0] fn;
        logic [7:0] bv;
        logic [7:0] rk;
        bit         typed;
        result_t    val;
    } row_t;

    function automatic result_t mk(logic [1:0] st, logic [7:0] sy, logic [23:0] fq,
                                   logic [63:0] cb, logic [6:0] cl, logic [8:0] ds);
        result_t r;
        r.status = st;
        r.symbol = sy;
        r.frequency = fq;
        r.code_bits = cb;
        r.code_length = cl;
        r.distinct = ds;
        return r;
    endfunction

    row_t directed [$];

    initial
    begin
        int          nsym;
        int          ncount;
        int          nquery;
        int          phase;
        bit          big_done;
        int          pool [$];
        logic [2:0]  fn;
        logic [7:0]  bv;
        logic [7:0]  rk;
        error_count = 0;
        items_sent = 0;
        words_checked = 0;
        builds_sent = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        big_done = 1'b0;
        for (int s = 0; s < 256; s++)
        begin
            sh_count[s] = '0;
            sh_len[s] = 0;
        end
        sh_leaves = 0;
        sh_ready = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Unbuilt, empty, unused codes, two-symbol tree, lone symbol.
        directed = '{
            '{FN_ENCODE, 8'd0,   8'd0,   1, mk(STAT_UNBUILT, 0, 0, 0, 0, 0)},
            '{FN_RANK,   8'd0,   8'd255, 1, mk(STAT_UNBUILT, 0, 0, 0, 0, 0)},
            '{FN_BUILD,  8'd0,   8'd0,   1, mk(STAT_NONE, 0, 0, 0, 0, 0)},
            '{FN_ENCODE, 8'd255, 8'd0,   1, mk(STAT_NONE, 255, 0, 0, 0, 0)},
            '{FN_RANK,   8'd0,   8'd0,   1, mk(STAT_NONE, 0, 0, 0, 0, 0)},
            '{3'd5,      8'd255, 8'd255, 1, mk(STAT_NONE, 0, 0, 0, 0, 0)},
            '{3'd6,      8'd0,   8'd0,   1, mk(STAT_NONE, 0, 0, 0, 0, 0)},
            '{3'd7,      8'd170, 8'd85,  1, mk(STAT_NONE, 0, 0, 0, 0, 0)},
            '{FN_COUNT,  8'd0,   8'd0,   1, mk(STAT_OK, 0, 1, 0, 0, 0)},
            '{FN_COUNT,  8'd255, 8'd0,   1, mk(STAT_OK, 255, 1, 0, 0, 0)},
            '{FN_COUNT,  8'd255, 8'd0,   1, mk(STAT_OK, 255, 2, 0, 0, 0)},
            '{FN_BUILD,  8'd0,   8'd0,   1, mk(STAT_OK, 0, 0, 0, 0, 2)},
            '{FN_ENCODE, 8'd0,   8'd0,   1, mk(STAT_OK, 0, 1, 0, 1, 2)},
            '{FN_ENCODE, 8'd255, 8'd0,   1, mk(STAT_OK, 255, 2, 1, 1, 2)},
            '{FN_RANK,   8'd0,   8'd1,   0, '0},
            '{FN_RANK,   8'd0,   8'd2,   1, mk(STAT_NONE, 0, 0, 0, 0, 2)},
            '{FN_COUNT,  8'd85,  8'd0,   1, mk(STAT_OK, 85, 1, 0, 0, 0)},
            '{FN_ENCODE, 8'd0,   8'd0,   1, mk(STAT_UNBUILT, 0, 0, 0, 0, 0)},
            '{FN_CLEAR,  8'd0,   8'd0,   1, mk(STAT_OK, 0, 0, 0, 0, 0)},
            '{FN_COUNT,  8'd7,   8'd0,   1, mk(STAT_OK, 7, 1, 0, 0, 0)},
            '{FN_BUILD,  8'd0,   8'd0,   1, mk(STAT_OK, 0, 0, 0, 0, 1)},
            '{FN_ENCODE, 8'd7,   8'd0,   1, mk(STAT_OK, 7, 1, 0, 1, 1)},
            '{FN_RANK,   8'd0,   8'd0,   1, mk(STAT_OK, 7, 1, 0, 1, 1)},
            '{FN_RANK,   8'd0,   8'd1,   1, mk(STAT_NONE, 0, 0, 0, 0, 1)},
            '{FN_ENCODE, 8'd8,   8'd0,   1, mk(STAT_NONE, 8, 0, 0, 0, 1)}
        };
        foreach (directed[i])
            send_word(directed[i].fn, directed[i].bv, directed[i].rk,
                      directed[i].typed, directed[i].val);

        // Random phases: usually clear, count a symbol set, build, then query.
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if (phase == 2)
                hold_req = 1'b1;
            if (!big_done && phase == 5)
            begin
                nsym = $urandom_range(120, 256);
                big_done = 1'b1;
            end
            else
                nsym = $urandom_range(1, 12);
            pool.delete();
            for (int i = 0; i < nsym; i++)
                pool.push_back(nsym >= 120 ? (i * 256 / nsym) : $urandom_range(0, 255));
            if ($urandom_range(0, 4) != 0)
                send_word(FN_CLEAR, 8'($urandom), 8'($urandom), 0, '0);
            ncount = (nsym >= 120) ? nsym + 40 : $urandom_range(nsym, 4 * nsym + 4);
            for (int i = 0; i < ncount; i++)
            begin
                if (i < nsym && nsym >= 120)
                    bv = 8'(pool[i]);
                else
                    bv = 8'(pool[$urandom_range(0, nsym - 1)]);
                send_word(FN_COUNT, bv, 8'($urandom), 0, '0);
            end
            // One phase lets the results catch up before the build.
            if (phase == 3)
                drain();
            send_word(FN_BUILD, 8'($urandom), 8'($urandom), 0, '0);
            nquery = $urandom_range(6, 20);
            for (int i = 0; i < nquery; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        fn = FN_ENCODE;
                        bv = 8'(pool[$urandom_range(0, nsym - 1)]);
                    end
                    4:
                    begin
                        fn = FN_ENCODE;
                        bv = 8'($urandom);
                    end
                    5, 6, 7:
                    begin
                        fn = FN_RANK;
                        bv = 8'($urandom);
                    end
                    8:
                    begin
                        fn = 3'($urandom_range(5, 7));
                        bv = 8'($urandom);
                    end
                    default:
                    begin
                        fn = ($urandom_range(0, 3) == 0) ? FN_BUILD : FN_COUNT;
                        bv = 8'(pool[$urandom_range(0, nsym - 1)]);
                    end
                endcase
                rk = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, nsym + 1));
                send_word(fn, bv, rk, 0, '0);
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge clk);
        $display("Sent %0d words over %0d random phases with %0d builds; checked %0d results.",
                 items_sent, phase, builds_sent, words_checked);
        if (error_count == 0 && pending_words.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", error_count, pending_words.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
hdl/hcb_pkg.sv
hdl/hcb_ram.sv
hdl/huffman_code_builder.sv
test/huffman_code_builder_tb.sv
